// ===== src/lsdrs_pkg.sv =====
// shared types and constants for the radix sort block
package lsdrs_pkg;

   // width of a key and of a per-key quotient
   localparam int KEY_W = 64;
   localparam int CSR_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_KEY    = 2'd1;

   // request modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_WAIT, ST_START, ST_FIN, ST_CLR,
      ST_CNT_RD, ST_CNT_LD, ST_CNT_DIV, ST_CNT_CRD, ST_CNT_WR,
      ST_PFX_RD, ST_PFX_WR, ST_SCT_RD, ST_SCT_LD, ST_SCT_WR,
      ST_CPY_RD, ST_CPY_WR, ST_MQ_ST, ST_MQ_DIV
   } state_type;

   typedef enum logic [4:0] {
      OP_IDLE, OP_RESP, OP_START, OP_FIN, OP_CLR,
      OP_CNT_RD, OP_CNT_LD, OP_CNT_WAIT, OP_CNT_CRD, OP_CNT_WR,
      OP_PFX_RD, OP_PFX_WR, OP_SCT_RD, OP_SCT_LD, OP_SCT_WR,
      OP_CPY_RD, OP_CPY_WR, OP_MQ_ST, OP_MQ_WAIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic acc_read;
      logic acc_fill;
      logic n_one;
      logic mq_zero;
      logic ix_last;
      logic ix_zero;
      logic div_done;
   } status_type;

endpackage

// ===== src/lsdrs_ram.sv =====
// generic single write port, single read port ram with registered read
module lsdrs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lsdrs_div.sv =====
// bit-serial restoring divider, 64-bit dividend by a narrow divisor
module lsdrs_div #(
   parameter int NW = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lsdrs_pkg::KEY_W-1:0]   dividend,
   input  logic [NW-1:0]                 divisor,
   output logic                          done,
   output logic [lsdrs_pkg::KEY_W-1:0]   quotient,
   output logic [NW-1:0]                 remainder
);
   import lsdrs_pkg::*;

   localparam int CW = $clog2(KEY_W);

   logic [KEY_W-1:0] q_ff, q_in;
   logic [NW-1:0]    r_ff, r_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NW:0]      trial;
   logic [NW:0]      diff;

   // one quotient bit per cycle
   always_comb begin
      trial   = {r_ff, q_ff[KEY_W-1]};
      diff    = trial - {1'b0, divisor};
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = diff[NW-1:0];
            q_in = {q_ff[KEY_W-2:0], 1'b1};
         end else begin
            r_in = trial[NW-1:0];
            q_in = {q_ff[KEY_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

// ===== src/lsdrs_ctrl.sv =====
// sequencer for load, read and the digit passes of the sort
module lsdrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  lsdrs_pkg::status_type  status,
   output lsdrs_pkg::cmd_type     cmd
);
   import lsdrs_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.acc_read) state_in = ST_RD_WAIT;
            else if (status.acc_fill) state_in = ST_START;
         end
         ST_RD_WAIT: state_in = ST_IDLE;
         ST_START: begin
            if (status.n_one || status.mq_zero) state_in = ST_FIN;
            else state_in = ST_CLR;
         end
         ST_FIN:     state_in = ST_IDLE;
         ST_CLR: begin
            if (status.ix_last) state_in = ST_CNT_RD;
         end
         ST_CNT_RD:  state_in = ST_CNT_LD;
         ST_CNT_LD:  state_in = ST_CNT_DIV;
         ST_CNT_DIV: begin
            if (status.div_done) state_in = ST_CNT_CRD;
         end
         ST_CNT_CRD: state_in = ST_CNT_WR;
         ST_CNT_WR: begin
            if (status.ix_last) state_in = ST_PFX_RD;
            else state_in = ST_CNT_RD;
         end
         ST_PFX_RD:  state_in = ST_PFX_WR;
         ST_PFX_WR: begin
            if (status.ix_last) state_in = ST_SCT_RD;
            else state_in = ST_PFX_RD;
         end
         ST_SCT_RD:  state_in = ST_SCT_LD;
         ST_SCT_LD:  state_in = ST_SCT_WR;
         ST_SCT_WR: begin
            if (status.ix_zero) state_in = ST_CPY_RD;
            else state_in = ST_SCT_RD;
         end
         ST_CPY_RD:  state_in = ST_CPY_WR;
         ST_CPY_WR: begin
            if (status.ix_last) state_in = ST_MQ_ST;
            else state_in = ST_CPY_RD;
         end
         ST_MQ_ST:   state_in = ST_MQ_DIV;
         ST_MQ_DIV: begin
            if (status.div_done) state_in = ST_START;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // command to the datapath
   always_comb begin
      case (state_ff)
         ST_IDLE:    cmd.op = OP_IDLE;
         ST_RD_WAIT: cmd.op = OP_RESP;
         ST_START:   cmd.op = OP_START;
         ST_FIN:     cmd.op = OP_FIN;
         ST_CLR:     cmd.op = OP_CLR;
         ST_CNT_RD:  cmd.op = OP_CNT_RD;
         ST_CNT_LD:  cmd.op = OP_CNT_LD;
         ST_CNT_DIV: cmd.op = OP_CNT_WAIT;
         ST_CNT_CRD: cmd.op = OP_CNT_CRD;
         ST_CNT_WR:  cmd.op = OP_CNT_WR;
         ST_PFX_RD:  cmd.op = OP_PFX_RD;
         ST_PFX_WR:  cmd.op = OP_PFX_WR;
         ST_SCT_RD:  cmd.op = OP_SCT_RD;
         ST_SCT_LD:  cmd.op = OP_SCT_LD;
         ST_SCT_WR:  cmd.op = OP_SCT_WR;
         ST_CPY_RD:  cmd.op = OP_CPY_RD;
         ST_CPY_WR:  cmd.op = OP_CPY_WR;
         ST_MQ_ST:   cmd.op = OP_MQ_ST;
         ST_MQ_DIV:  cmd.op = OP_MQ_WAIT;
         default:    cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/lsdrs_dp.sv =====
// datapath: key stores, digit counts, divider and handshake registers
module lsdrs_dp #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lsdrs_pkg::cmd_type                    cmd,
   output lsdrs_pkg::status_type                 status,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic [lsdrs_pkg::KEY_W-1:0]           req_key_in,
   input  logic [9:0]                            req_read_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lsdrs_pkg::KEY_W-1:0]           rsp_key_out,
   output logic                                  rsp_sorted_ready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lsdrs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lsdrs_pkg::KEY_W-1:0]           csr_data
);
   import lsdrs_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int NW = $clog2(MAX_ITEMS + 1);
   localparam int WW = 2 * KEY_W + AW;

   // configuration and sort state
   logic [10:0]      item_count_ff, item_count_in;
   logic [KEY_W-1:0] max_key_ff, max_key_in;
   logic [NW-1:0]    loaded_ff, loaded_in;
   logic             done_ff, done_in;
   logic [KEY_W-1:0] mq_ff, mq_in;
   logic [AW-1:0]    ix_ff, ix_in;
   logic [NW-1:0]    acc_ff, acc_in;
   logic [WW-1:0]    hold_ff, hold_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic             rsp_rdy_ff, rsp_rdy_in;

   logic [NW-1:0]    n_eff;
   logic             accept;
   logic             do_load;
   logic [NW-1:0]    loaded_inc;
   logic [NW-1:0]    pos;
   logic [NW-1:0]    sum;

   // memory ports
   logic             ks_we, pb_we, ct_we;
   logic [AW-1:0]    ks_wa, ks_ra, pb_wa, pb_ra, ct_wa, ct_ra;
   logic [WW-1:0]    ks_wd, ks_rd, pb_wd, pb_rd;
   logic [NW-1:0]    ct_wd, ct_rd;

   // divider
   logic             div_start;
   logic [KEY_W-1:0] div_a, div_q;
   logic [NW-1:0]    div_r;
   logic             div_done;

   // radix, with item_count clamped to one through the store depth
   always_comb begin
      if (item_count_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(item_count_ff) > 32'(MAX_ITEMS)) begin
         n_eff = NW'(MAX_ITEMS);
      end else begin
         n_eff = NW'(item_count_ff);
      end
   end

   assign req_stall  = (cmd.op != OP_IDLE) || rsp_valid_ff;
   assign accept     = req_valid && !req_stall;
   assign do_load    = accept && (req_mode == MODE_LOAD) && !done_ff && (loaded_ff < n_eff);
   assign loaded_inc = loaded_ff + 1'b1;
   assign pos        = ct_rd - 1'b1;
   assign sum        = acc_ff + ct_rd;
   assign csr_ready  = 1'b1;

   assign status.acc_read = accept && (req_mode == MODE_READ);
   assign status.acc_fill = do_load && (loaded_inc == n_eff);
   assign status.n_one    = (n_eff == NW'(1));
   assign status.mq_zero  = (mq_ff == '0);
   assign status.ix_last  = (NW'(ix_ff) == n_eff - 1'b1);
   assign status.ix_zero  = (ix_ff == '0);
   assign status.div_done = div_done;

   // command decode: memory ports, divider and register updates
   always_comb begin
      item_count_in = item_count_ff;
      max_key_in    = max_key_ff;
      loaded_in     = loaded_ff;
      done_in       = done_ff;
      mq_in         = mq_ff;
      ix_in         = ix_ff;
      acc_in        = acc_ff;
      hold_in       = hold_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_key_in    = rsp_key_ff;
      rsp_rdy_in    = rsp_rdy_ff;
      ks_we = 1'b0; ks_wa = ix_ff; ks_wd = ks_rd; ks_ra = ix_ff;
      pb_we = 1'b0; pb_wa = AW'(pos); pb_wd = hold_ff; pb_ra = ix_ff;
      ct_we = 1'b0; ct_wa = ix_ff; ct_wd = '0; ct_ra = ix_ff;
      div_start = 1'b0;
      div_a     = mq_ff;

      // configuration writes
      if (csr_valid) begin
         if (csr_index == CSR_ITEM_COUNT) begin
            item_count_in = csr_data[10:0];
            loaded_in     = '0;
            done_in       = 1'b0;
         end else if (csr_index == CSR_MAX_KEY) begin
            max_key_in = csr_data;
         end
      end

      case (cmd.op)
         OP_IDLE: begin
            ks_ra  = AW'(req_read_index);
            hit_in = done_ff && (32'(req_read_index) < 32'(loaded_ff));
            if (do_load) begin
               ks_we     = 1'b1;
               ks_wa     = AW'(loaded_ff);
               ks_wd     = {req_key_in, req_key_in, AW'(0)};
               loaded_in = loaded_inc;
               mq_in     = max_key_ff;
            end
         end
         OP_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = hit_ff ? ks_rd[WW-1 -: KEY_W] : '0;
            rsp_rdy_in   = done_ff;
         end
         OP_START: begin
            ix_in  = '0;
            acc_in = '0;
         end
         OP_FIN: begin
            done_in = 1'b1;
         end
         OP_CLR: begin
            ct_we = 1'b1;
            ix_in = status.ix_last ? '0 : ix_ff + 1'b1;
         end
         OP_CNT_LD: begin
            div_start = 1'b1;
            div_a     = ks_rd[AW +: KEY_W];
            hold_in   = ks_rd;
         end
         OP_CNT_CRD: begin
            ct_ra = AW'(div_r);
            ks_we = 1'b1;
            ks_wd = {hold_ff[WW-1 -: KEY_W], div_q, AW'(div_r)};
         end
         OP_CNT_WR: begin
            ct_we = 1'b1;
            ct_wa = AW'(div_r);
            ct_wd = ct_rd + 1'b1;
            ix_in = status.ix_last ? '0 : ix_ff + 1'b1;
         end
         OP_PFX_WR: begin
            ct_we  = 1'b1;
            ct_wd  = sum;
            acc_in = sum;
            ix_in  = status.ix_last ? ix_ff : ix_ff + 1'b1;
         end
         OP_SCT_LD: begin
            hold_in = ks_rd;
            ct_ra   = ks_rd[AW-1:0];
         end
         OP_SCT_WR: begin
            ct_we = 1'b1;
            ct_wa = hold_ff[AW-1:0];
            ct_wd = pos;
            pb_we = 1'b1;
            ix_in = status.ix_zero ? '0 : ix_ff - 1'b1;
         end
         OP_CPY_WR: begin
            ks_we = 1'b1;
            ks_wd = pb_rd;
            ix_in = status.ix_last ? '0 : ix_ff + 1'b1;
         end
         OP_MQ_ST: begin
            div_start = 1'b1;
         end
         OP_MQ_WAIT: begin
            if (div_done) mq_in = div_q;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= 11'd1;
         max_key_ff    <= '0;
         loaded_ff     <= '0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_count_ff <= item_count_in;
         max_key_ff    <= max_key_in;
         loaded_ff     <= loaded_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mq_ff      <= mq_in;
      ix_ff      <= ix_in;
      acc_ff     <= acc_in;
      hold_ff    <= hold_in;
      hit_ff     <= hit_in;
      rsp_key_ff <= rsp_key_in;
      rsp_rdy_ff <= rsp_rdy_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_out      = rsp_key_ff;
   assign rsp_sorted_ready = rsp_rdy_ff;

   // key store: key, running quotient and current digit per entry
   lsdrs_ram #(.WIDTH(WW), .DEPTH(MAX_ITEMS)) u_key_store (
      .clock(clock), .wr_en(ks_we), .wr_addr(ks_wa), .wr_data(ks_wd),
      .rd_addr(ks_ra), .rd_data(ks_rd)
   );

   // scatter target of one pass
   lsdrs_ram #(.WIDTH(WW), .DEPTH(MAX_ITEMS)) u_pass_buf (
      .clock(clock), .wr_en(pb_we), .wr_addr(pb_wa), .wr_data(pb_wd),
      .rd_addr(pb_ra), .rd_data(pb_rd)
   );

   // digit counts, then bucket end positions
   lsdrs_ram #(.WIDTH(NW), .DEPTH(MAX_ITEMS)) u_counts (
      .clock(clock), .wr_en(ct_we), .wr_addr(ct_wa), .wr_data(ct_wd),
      .rd_addr(ct_ra), .rd_data(ct_rd)
   );

   lsdrs_div #(.NW(NW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(n_eff), .done(div_done), .quotient(div_q), .remainder(div_r)
   );

endmodule

// ===== src/lsd_radix_sort_base_count.sv =====
// top level of the radix sort block
// Loads up to MAX_ITEMS unsigned 64-bit keys and sorts them ascending by LSD radix
// sort with radix n = item_count. A load request is written into the key store as it
// is taken. A read request moves the sequencer to its response state, which fills the
// registered response, and the next request is taken the cycle after that response
// leaves. When the n-th key arrives the block sorts and accepts no request until done.
// The time is set by the bit-serial divider, run once per key per pass, and the
// single-port sweeps over the count and key memories; passes run while max_key
// divided by the place value is nonzero, each pass also running the divider once
// more to advance that quotient. Configuration writes are always taken.
module lsd_radix_sort_base_count #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic [lsdrs_pkg::KEY_W-1:0]           req_key_in,
   input  logic [9:0]                            req_read_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lsdrs_pkg::KEY_W-1:0]           rsp_key_out,
   output logic                                  rsp_sorted_ready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lsdrs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lsdrs_pkg::KEY_W-1:0]           csr_data
);
   import lsdrs_pkg::*;

   cmd_type    cmd;
   status_type status;

   lsdrs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .status(status), .cmd(cmd)
   );

   lsdrs_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_key_in(req_key_in), .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_key_out(rsp_key_out),
      .rsp_sorted_ready(rsp_sorted_ready),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

endmodule

// ===== dv/tb_lsd_radix_sort_base_count.sv =====
// self-checking testbench for the radix sort block
`timescale 1ns / 1ps

module tb_lsd_radix_sort_base_count;
   import lsdrs_pkg::*;

   localparam int MAX_N = 1024;
   localparam int RAND_ITEMS = 1150;

   // directed row kinds and how a row's expectation is formed
   localparam int ROW_CSR = 0;
   localparam int ROW_REQ = 1;
   localparam int EXP_MODEL = 0;
   localparam int EXP_LITERAL = 1;

   // idle phases
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_mode;
   logic [KEY_W-1:0] req_key_in;
   logic [9:0] req_read_index;
   logic rsp_valid;
   logic rsp_stall;
   logic [KEY_W-1:0] rsp_key_out;
   logic rsp_sorted_ready;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [KEY_W-1:0] csr_data;

   typedef struct {
      logic [KEY_W-1:0] key_out;
      logic sorted_ready;
   } sorted_read_type;

   typedef struct {
      int kind;
      logic [CSR_IDX_W-1:0] index;
      logic [KEY_W-1:0] data;
      logic mode;
      logic [9:0] read_index;
      int exp_kind;
      logic [KEY_W-1:0] exp_key;
      logic exp_ready;
   } stim_row_type;

   sorted_read_type pending_reads[$];
   int error_count = 0;
   int idle_phase = IDLE_NONE;
   int req_items = 0;

   // shadow copy of the block state
   logic [10:0] shadow_count;
   logic [KEY_W-1:0] shadow_max;
   logic [KEY_W-1:0] shadow_keys[MAX_N];
   logic [KEY_W-1:0] shadow_scratch[MAX_N];
   int unsigned shadow_buckets[MAX_N];
   int unsigned shadow_loaded;
   logic shadow_sorted;

   lsd_radix_sort_base_count dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_key_in(req_key_in), .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_key_out(rsp_key_out),
      .rsp_sorted_ready(rsp_sorted_ready),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #200_000_000;
      $display("tb_lsd_radix_sort_base_count: errors");
      $finish;
   end

   function automatic int unsigned radix_of();
      if (shadow_count == 11'd0) return 1;
      if (shadow_count > 11'd1024) return MAX_N;
      return shadow_count;
   endfunction

   // one stable counting pass on digit (key / place) mod n
   function automatic void digit_sweep(input int unsigned n, input logic [KEY_W-1:0] place);
      int unsigned d;
      int unsigned pos;
      for (int i = 0; i < MAX_N; i++) shadow_buckets[i] = 0;
      for (int i = 0; i < n; i++) begin
         d = (shadow_keys[i] / place) % n;
         shadow_buckets[d]++;
      end
      for (int i = 1; i < n; i++) shadow_buckets[i] += shadow_buckets[i-1];
      for (int i = n - 1; i >= 0; i--) begin
         d = (shadow_keys[i] / place) % n;
         pos = shadow_buckets[d] - 1;
         shadow_buckets[d] = pos;
         shadow_scratch[pos] = shadow_keys[i];
      end
      for (int i = 0; i < n; i++) shadow_keys[i] = shadow_scratch[i];
   endfunction

   // full lsd sort, stopping before the place value would overflow
   function automatic void sort_shadow(input int unsigned n);
      logic [KEY_W-1:0] place;
      place = 64'd1;
      if (n >= 2) begin
         while (shadow_max / place != 64'd0) begin
            digit_sweep(n, place);
            if (place > 64'hFFFF_FFFF_FFFF_FFFF / n) break;
            place = place * n;
         end
      end
      shadow_sorted = 1'b1;
   endfunction

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] index, input logic [KEY_W-1:0] data);
      if (index == CSR_ITEM_COUNT) begin
         shadow_count = data[10:0];
         shadow_loaded = 0;
         shadow_sorted = 1'b0;
      end else if (index == CSR_MAX_KEY) begin
         shadow_max = data;
      end
   endtask

   // update shadow state for one request, returns 1 if a response follows
   function automatic bit predict_request(input logic mode, input logic [KEY_W-1:0] key,
                                          input logic [9:0] ridx,
                                          output sorted_read_type rd);
      int unsigned n;
      n = radix_of();
      rd.key_out = '0;
      rd.sorted_ready = 1'b0;
      if (mode == MODE_LOAD) begin
         if (!shadow_sorted && shadow_loaded < n) begin
            shadow_keys[shadow_loaded] = key;
            shadow_loaded++;
            if (shadow_loaded == n) sort_shadow(n);
         end
         return 1'b0;
      end
      if (shadow_sorted && ridx < shadow_loaded) rd.key_out = shadow_keys[ridx];
      rd.sorted_ready = shadow_sorted;
      return 1'b1;
   endfunction

   // sender gap according to the idle phase
   task automatic sender_gap();
      if (idle_phase == IDLE_SEND || idle_phase == IDLE_BOTH) begin
         while ($urandom_range(99) < ((idle_phase == IDLE_BOTH) ? 9 : 81)) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
   endtask

   // drain responses, then let a busy block settle before a register write
   task automatic wait_idle();
      while (pending_reads.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [KEY_W-1:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // send one request; literal expectation overrides the shadow prediction
   task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                               input logic [9:0] ridx, input bit literal,
                               input sorted_read_type lit);
      sorted_read_type rd;
      bit has_rsp;
      sender_gap();
      req_valid <= 1'b1;
      req_mode <= mode;
      req_key_in <= key;
      req_read_index <= ridx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has_rsp = predict_request(mode, key, ridx, rd);
      if (has_rsp) begin
         if (literal) pending_reads.push_back(lit);
         else pending_reads.push_back(rd);
      end
      req_items++;
      @(negedge clock);
   endtask

   task automatic release_sender();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // receiver stall
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (idle_phase == IDLE_RECV)
         rsp_stall <= ($urandom_range(99) < 81);
      else if (idle_phase == IDLE_BOTH)
         rsp_stall <= ($urandom_range(99) < 9);
      else rsp_stall <= 1'b0;
   end

   // response checker
   always @(posedge clock) begin
      sorted_read_type exp_rd;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            $error("unexpected response key_out=%h sorted_ready=%b", rsp_key_out,
                   rsp_sorted_ready);
            error_count++;
         end else begin
            exp_rd = pending_reads.pop_front();
            if (rsp_key_out !== exp_rd.key_out) begin
               $error("key_out expected %h actual %h", exp_rd.key_out, rsp_key_out);
               error_count++;
            end
            if (rsp_sorted_ready !== exp_rd.sorted_ready) begin
               $error("sorted_ready expected %b actual %b", exp_rd.sorted_ready,
                      rsp_sorted_ready);
               error_count++;
            end
         end
      end
   end

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] index,
                                            input logic [KEY_W-1:0] data);
      stim_row_type r;
      r = '{ROW_CSR, index, data, MODE_LOAD, 10'd0, EXP_MODEL, 64'd0, 1'b0};
      return r;
   endfunction

   function automatic stim_row_type req_row(input logic mode, input logic [KEY_W-1:0] key,
                                            input logic [9:0] ridx, input int exp_kind,
                                            input logic [KEY_W-1:0] exp_key,
                                            input logic exp_ready);
      stim_row_type r;
      r = '{ROW_REQ, CSR_ITEM_COUNT, 64'd0, mode, ridx, exp_kind, exp_key, exp_ready};
      r.data = key;
      return r;
   endfunction

   // random key of a given bit width
   function automatic logic [KEY_W-1:0] rand_key(input int w);
      logic [KEY_W-1:0] k;
      k = {$urandom, $urandom};
      if (w < 64) k = k & ((64'd1 << w) - 64'd1);
      return k;
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      sorted_read_type lit;
      int set_no;
      int n;
      int w;
      int reads;
      logic [10:0] cnt_val;
      logic [KEY_W-1:0] ones;

      ones = '1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_LOAD;
      req_key_in = '0;
      req_read_index = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ITEM_COUNT;
      csr_data = '0;
      shadow_count = 11'd1;
      shadow_max = '0;
      shadow_loaded = 0;
      shadow_sorted = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd0, EXP_LITERAL, 64'd0, 1'b0));
      rows.push_back(csr_row(CSR_ITEM_COUNT, 64'd0));
      rows.push_back(req_row(MODE_LOAD, ones, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd0, EXP_LITERAL, ones, 1'b1));
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd1023, EXP_LITERAL, 64'd0, 1'b1));
      rows.push_back(req_row(MODE_LOAD, 64'd5, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(csr_row(CSR_ITEM_COUNT, 64'd2));
      rows.push_back(csr_row(CSR_MAX_KEY, ones));
      rows.push_back(req_row(MODE_LOAD, ones, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_LOAD, 64'd0, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd0, EXP_LITERAL, 64'd0, 1'b1));
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd1, EXP_LITERAL, ones, 1'b1));
      rows.push_back(csr_row(CSR_ITEM_COUNT, 64'd3));
      rows.push_back(csr_row(CSR_MAX_KEY, 64'd10));
      rows.push_back(req_row(MODE_LOAD, 64'd20, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_LOAD, 64'd7, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd2, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_LOAD, 64'd3, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd1, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd2, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(csr_row(CSR_ITEM_COUNT, 64'd4));
      rows.push_back(req_row(MODE_LOAD, 64'd9, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(csr_row(CSR_ITEM_COUNT, 64'd1));
      rows.push_back(req_row(MODE_LOAD, 64'd6, 10'd0, EXP_MODEL, 64'd0, 1'b0));
      rows.push_back(req_row(MODE_READ, 64'd0, 10'd0, EXP_MODEL, 64'd0, 1'b0));

      foreach (rows[i]) begin
         r = rows[i];
         if (r.kind == ROW_CSR) begin
            release_sender();
            write_csr(r.index, r.data);
         end else begin
            lit.key_out = r.exp_key;
            lit.sorted_ready = r.exp_ready;
            send_request(r.mode, r.data, r.read_index, r.exp_kind == EXP_LITERAL, lit);
         end
      end
      release_sender();

      // one full-size set, count written above range so it clamps
      write_csr(CSR_ITEM_COUNT, 64'd2047);
      write_csr(CSR_MAX_KEY, 64'd1000);
      for (int i = 0; i < MAX_N; i++)
         send_request(MODE_LOAD, 64'($urandom_range(1000)), 10'd0, 1'b0, lit);
      for (int i = 0; i < 12; i++)
         send_request(MODE_READ, 64'd0, 10'($urandom), 1'b0, lit);
      send_request(MODE_READ, 64'd0, 10'd1023, 1'b0, lit);
      release_sender();

      // random sets of small size until the request budget is spent
      set_no = 0;
      while (req_items < RAND_ITEMS) begin
         idle_phase = set_no % 4;
         set_no++;
         release_sender();
         if ($urandom_range(7) == 0) cnt_val = ($urandom_range(1) == 0) ? 11'd0
                                                : 11'($urandom_range(13, 30));
         else cnt_val = 11'($urandom_range(1, 12));
         n = (cnt_val == 0) ? 1 : cnt_val;
         if ($urandom_range(9) == 0 && n <= 12) w = 64;
         else w = $urandom_range(0, 24);
         if ($urandom_range(1) == 0 || set_no == 1) write_csr(CSR_MAX_KEY, rand_key(w));
         write_csr(CSR_ITEM_COUNT, {53'd0, cnt_val});
         // loads with some early reads mixed in
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
               send_request(MODE_READ, rand_key(64), 10'($urandom), 1'b0, lit);
            if ($urandom_range(7) == 0) send_request(MODE_LOAD, rand_key(64), 10'($urandom),
                                                     1'b0, lit);
            else send_request(MODE_LOAD, rand_key(w), 10'($urandom), 1'b0, lit);
         end
         if ($urandom_range(4) == 0)
            send_request(MODE_LOAD, rand_key(64), 10'd0, 1'b0, lit);
         reads = $urandom_range(1, n + 2);
         for (int i = 0; i < reads; i++) begin
            if ($urandom_range(5) == 0)
               send_request(MODE_READ, rand_key(64), 10'($urandom), 1'b0, lit);
            else
               send_request(MODE_READ, rand_key(64), 10'($urandom_range(n + 1)), 1'b0, lit);
         end
         // sometimes hold off until all responses are back
         if ($urandom_range(3) == 0) begin
            release_sender();
            while (pending_reads.size() != 0) @(negedge clock);
         end
      end
      release_sender();
      idle_phase = IDLE_NONE;

      while (pending_reads.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (error_count == 0 && pending_reads.size() == 0)
         $display("tb_lsd_radix_sort_base_count: clean");
      else
         $display("tb_lsd_radix_sort_base_count: errors");
      $finish;
   end

endmodule
